// ----- src/vcms_pkg.sv -----
// vcms_pkg: shared constants, types and helpers for the voq crossbar match scheduler
// used by vcms_qstore and voq_crossbar_match_scheduler; no dependencies
package vcms_pkg;

  // build-time sizing
  localparam int MAX_PORTS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int LANES       = 8;

  // derived widths
  localparam int PORT_W   = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int CNT_W    = $clog2(MAX_PORTS + 1);
  localparam int LANE_W   = $clog2(LANES);
  localparam int QS_DEPTH = MAX_PORTS * MAX_PORTS;
  localparam int ADDR_W   = $clog2(QS_DEPTH);
  localparam int WGT_W    = COUNT_WIDTH + PORT_W;

  // fixed field widths of the stream words
  localparam int DEST_W   = 3;
  localparam int CFG_W    = 4;
  localparam int SENT_W   = 4;
  localparam int SENT_MAX = 15;
  localparam int MIN_PORTS = 2;

  localparam int IN_BITS     = LANES + LANES * DEST_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = LANES * DEST_W + LANES + SENT_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // read request for the two read ports of the queue-count store
  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } qs_rd_t;

  // write request for the queue-count store
  typedef struct packed {
    logic                   en;
    logic [ADDR_W-1:0]      addr;
    logic [COUNT_WIDTH-1:0] data;
  } qs_wr_t;

  // flat address of queue (input row, output col)
  function automatic logic [ADDR_W-1:0] qaddr(input logic [PORT_W-1:0] row,
                                              input logic [PORT_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_PORTS) + ADDR_W'(col));
  endfunction

endpackage

// ----- src/vcms_qstore.sv -----
// vcms_qstore: queue occupancy count store, two registered read ports, one write port
// entries never written since reset or clear read as zero; depends on vcms_pkg
module vcms_qstore import vcms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clr,
  input  qs_rd_t                 rd,
  input  qs_wr_t                 wr,
  output logic [COUNT_WIDTH-1:0] rd_data_a,
  output logic [COUNT_WIDTH-1:0] rd_data_b
);

  logic [COUNT_WIDTH-1:0] mem [QS_DEPTH];
  logic [QS_DEPTH-1:0]    vld;
  logic [COUNT_WIDTH-1:0] q_a;
  logic [COUNT_WIDTH-1:0] q_b;
  logic                   v_a;
  logic                   v_b;

  // storage array and registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    q_a <= mem[rd.addr_a];
    q_b <= mem[rd.addr_b];
    v_a <= vld[rd.addr_a];
    v_b <= vld[rd.addr_b];
  end

  // per-entry valid bits, cleared at once
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  assign rd_data_a = v_a ? q_a : '0;
  assign rd_data_b = v_b ? q_b : '0;

endmodule

// ----- src/voq_crossbar_match_scheduler.sv -----
// voq_crossbar_match_scheduler: one input word is one time slot, one output word per slot
// s_tready stays low from accept until the slot's result is loaded into the output register, so a
// new slot is taken only after the previous one has been processed; the processing time is set
// by the queue-count store ports and the single swap-weight pipe
// rst clears all queue counts, sets the matching to identity, slot index to one, ports to max
// a write of active_ports does the same for the new port count; depends on vcms_pkg, vcms_qstore
module voq_crossbar_match_scheduler import vcms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,      // active_ports
  // slot input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,        // arrival_valid_mask, arrival_dest_0..7
  // slot result
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata         // match_out_0..7, served_mask, sent_count
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ARRIVE = 7'b0000010,
    ST_DIAG   = 7'b0000100,
    ST_SWAP   = 7'b0001000,
    ST_PICK   = 7'b0010000,
    ST_SERVE  = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state;

  // configuration and slot state
  logic [CNT_W-1:0]       n;
  logic [PORT_W-1:0]      slot;
  logic [PORT_W-1:0]      match_q [MAX_PORTS];
  logic [COUNT_WIDTH-1:0] diag [MAX_PORTS];

  // latched input word
  logic [LANES-1:0]       mask_r;
  logic [DEST_W-1:0]      dest_r [LANES];

  // sequencer counters
  logic [CNT_W-1:0]       row;
  logic [CNT_W-1:0]       col;

  // read-side stage for arrive, diag and serve
  logic                   p_vld;
  logic [PORT_W-1:0]      p_row;
  logic [PORT_W-1:0]      p_col;

  // weights
  logic [WGT_W-1:0]       base_w;
  logic [WGT_W-1:0]       cyc_w;
  logic [WGT_W-1:0]       best_w;
  logic [WGT_W-1:0]       base_sum;

  // swap evaluation pipe
  logic                   iss_done;
  logic [PORT_W-1:0]      m_i;
  logic [COUNT_WIDTH-1:0] diag_i;
  logic [PORT_W-1:0]      nxt_m;
  logic [COUNT_WIDTH-1:0] nxt_diag;
  logic                   s1_vld;
  logic [WGT_W-1:0]       s1_part;
  logic [PORT_W-1:0]      s1_row;
  logic [PORT_W-1:0]      s1_col;
  logic [PORT_W-1:0]      s1_mi;
  logic [PORT_W-1:0]      s1_mj;
  logic                   s2_vld;
  logic [WGT_W-1:0]       cand_w;
  logic [PORT_W-1:0]      s2_row;
  logic [PORT_W-1:0]      s2_col;
  logic [PORT_W-1:0]      s2_mi;
  logic [PORT_W-1:0]      s2_mj;
  logic                   best_swap;
  logic [PORT_W-1:0]      b_row;
  logic [PORT_W-1:0]      b_col;
  logic [PORT_W-1:0]      b_mi;
  logic [PORT_W-1:0]      b_mj;

  // serve results
  logic [LANES-1:0]       served;
  logic [CNT_W-1:0]       sent;

  // output register
  logic [DEST_W-1:0]      out_match [LANES];
  logic [LANES-1:0]       out_served;
  logic [SENT_W-1:0]      out_sent;

  // store interface
  qs_rd_t                 qs_rd;
  qs_wr_t                 qs_wr;
  logic [COUNT_WIDTH-1:0] rd_a;
  logic [COUNT_WIDTH-1:0] rd_b;

  // helpers
  logic [PORT_W-1:0]      col_idx;
  logic [PORT_W-1:0]      row_idx;
  logic [PORT_W-1:0]      m_col;
  logic [COUNT_WIDTH-1:0] d_col;
  logic [LANE_W-1:0]      lane;
  logic [DEST_W-1:0]      arr_dest;
  logic                   arr_ok;
  logic                   col_live;
  logic [CNT_W:0]         cyc_sum;
  logic [PORT_W-1:0]      cyc_col;
  logic [CNT_W-1:0]       col_inc;
  logic [CNT_W-1:0]       row_inc;
  logic [CNT_W-1:0]       row_inc2;
  logic [CNT_W-1:0]       n_dec;
  logic [CNT_W-1:0]       n_dec2;
  logic [CNT_W-1:0]       slot_inc;
  logic [CNT_W-1:0]       cfg_n;

  vcms_qstore u_qstore (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_we),
    .rd        (qs_rd),
    .wr        (qs_wr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // index and address helpers
  always_comb begin
    col_idx  = col[PORT_W-1:0];
    row_idx  = row[PORT_W-1:0];
    m_col    = match_q[col_idx];
    d_col    = diag[col_idx];
    lane     = LANE_W'(col);
    arr_dest = dest_r[lane];
    arr_ok   = (32'(col) < LANES) && mask_r[lane] && (32'(arr_dest) < 32'(n));
    col_live = (col < n);
    cyc_sum  = {1'b0, col} + (CNT_W + 1)'(slot);
    cyc_col  = (cyc_sum >= {1'b0, n}) ? PORT_W'(cyc_sum - {1'b0, n}) : PORT_W'(cyc_sum);
    col_inc  = col + CNT_W'(1);
    row_inc  = row + CNT_W'(1);
    row_inc2 = row + CNT_W'(2);
    n_dec    = n - CNT_W'(1);
    n_dec2   = n - CNT_W'(2);
    slot_inc = CNT_W'(slot) + CNT_W'(1);
    base_sum = base_w + WGT_W'(rd_a);
    // clamp of the written port count
    if (32'(cfg_wdata) < MIN_PORTS) begin
      cfg_n = CNT_W'(MIN_PORTS);
    end else if (32'(cfg_wdata) > MAX_PORTS) begin
      cfg_n = CNT_W'(MAX_PORTS);
    end else begin
      cfg_n = CNT_W'(cfg_wdata);
    end
  end

  // store read addresses by phase
  always_comb begin
    qs_rd = '0;
    unique case (state)
      ST_ARRIVE: begin
        qs_rd.addr_a = qaddr(col_idx, PORT_W'(arr_dest));
      end
      ST_DIAG: begin
        qs_rd.addr_a = qaddr(col_idx, m_col);
        qs_rd.addr_b = qaddr(col_idx, cyc_col);
      end
      ST_SWAP: begin
        qs_rd.addr_a = qaddr(row_idx, m_col);
        qs_rd.addr_b = qaddr(col_idx, m_i);
      end
      ST_SERVE: begin
        qs_rd.addr_a = qaddr(col_idx, m_col);
      end
      default: begin
        qs_rd = '0;
      end
    endcase
  end

  // store write: arrival increment or service decrement
  always_comb begin
    qs_wr.addr = qaddr(p_row, p_col);
    if (state == ST_ARRIVE) begin
      qs_wr.en   = p_vld && (rd_a != COUNT_MAX);
      qs_wr.data = rd_a + COUNT_WIDTH'(1);
    end else begin
      qs_wr.en   = p_vld && (state == ST_SERVE) && (rd_a != '0);
      qs_wr.data = rd_a - COUNT_WIDTH'(1);
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      n        <= CNT_W'(MAX_PORTS);
      slot     <= PORT_W'(1);
      m_tvalid <= 1'b0;
      p_vld    <= 1'b0;
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      iss_done <= 1'b0;
      for (int k = 0; k < MAX_PORTS; k++) begin
        match_q[k] <= PORT_W'(k);
      end
    end else begin
      // new switch size restarts the slot state
      if (cfg_we) begin
        n    <= cfg_n;
        slot <= PORT_W'(1);
        for (int k = 0; k < MAX_PORTS; k++) begin
          match_q[k] <= PORT_W'(k);
        end
      end

      // result word taken, the final step reloads it itself
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mask_r <= s_tdata[LANES-1:0];
            for (int k = 0; k < LANES; k++) begin
              dest_r[k] <= s_tdata[LANES + k*DEST_W +: DEST_W];
            end
            col    <= '0;
            base_w <= '0;
            cyc_w  <= '0;
            state  <= ST_ARRIVE;
          end
        end

        // one arrival per cycle, read then write back
        ST_ARRIVE: begin
          p_vld <= col_live && arr_ok;
          p_row <= col_idx;
          p_col <= PORT_W'(arr_dest);
          if (col == n) begin
            col   <= '0;
            state <= ST_DIAG;
          end else begin
            col <= col_inc;
          end
        end

        // weights of the current and cyclic matchings
        ST_DIAG: begin
          p_vld <= col_live;
          p_row <= col_idx;
          if (col == '0) begin
            m_i <= m_col;
          end
          if (p_vld) begin
            diag[p_row] <= rd_a;
            base_w      <= base_sum;
            best_w      <= base_sum;
            cyc_w       <= cyc_w + WGT_W'(rd_b);
            if (p_row == '0) begin
              diag_i <= rd_a;
            end
          end
          if (col == n) begin
            row       <= '0;
            col       <= CNT_W'(1);
            iss_done  <= 1'b0;
            best_swap <= 1'b0;
            state     <= ST_SWAP;
          end else begin
            col <= col_inc;
          end
        end

        // one swap neighbor issued per cycle, three-stage weigh and compare
        ST_SWAP: begin
          s1_vld <= !iss_done;
          if (!iss_done) begin
            s1_part <= base_w - WGT_W'(diag_i) - WGT_W'(d_col);
            s1_row  <= row_idx;
            s1_col  <= col_idx;
            s1_mi   <= m_i;
            s1_mj   <= m_col;
            // pick up the next row's own entry as it passes
            if (col == row_inc) begin
              nxt_m    <= m_col;
              nxt_diag <= d_col;
            end
            if (col == n_dec) begin
              if (row == n_dec2) begin
                iss_done <= 1'b1;
              end else begin
                row    <= row_inc;
                col    <= row_inc2;
                m_i    <= nxt_m;
                diag_i <= nxt_diag;
              end
            end else begin
              col <= col_inc;
            end
          end
          // candidate weight
          s2_vld <= s1_vld;
          cand_w <= s1_part + WGT_W'(rd_a) + WGT_W'(rd_b);
          s2_row <= s1_row;
          s2_col <= s1_col;
          s2_mi  <= s1_mi;
          s2_mj  <= s1_mj;
          // strict improvement only
          if (s2_vld && (cand_w > best_w)) begin
            best_w    <= cand_w;
            best_swap <= 1'b1;
            b_row     <= s2_row;
            b_col     <= s2_col;
            b_mi      <= s2_mi;
            b_mj      <= s2_mj;
          end
          if (iss_done && !s1_vld && !s2_vld) begin
            state <= ST_PICK;
          end
        end

        // commit the heaviest matching
        ST_PICK: begin
          if (cyc_w > best_w) begin
            for (int k = 0; k < MAX_PORTS; k++) begin
              if (32'(k) < 32'(n)) begin
                if (32'(k) + 32'(slot) >= 32'(n)) begin
                  match_q[k] <= PORT_W'(32'(k) + 32'(slot) - 32'(n));
                end else begin
                  match_q[k] <= PORT_W'(32'(k) + 32'(slot));
                end
              end
            end
          end else if (best_swap) begin
            for (int k = 0; k < MAX_PORTS; k++) begin
              if (PORT_W'(k) == b_row) begin
                match_q[k] <= b_mj;
              end else if (PORT_W'(k) == b_col) begin
                match_q[k] <= b_mi;
              end
            end
          end
          col    <= '0;
          served <= '0;
          sent   <= '0;
          state  <= ST_SERVE;
        end

        // one packet per matched non-empty queue
        ST_SERVE: begin
          p_vld <= col_live;
          p_row <= col_idx;
          p_col <= m_col;
          if (p_vld && (rd_a != '0)) begin
            sent <= sent + CNT_W'(1);
            if (32'(p_row) < LANES) begin
              served[LANE_W'(p_row)] <= 1'b1;
            end
          end
          if (col == n) begin
            slot  <= (slot_inc == n) ? '0 : PORT_W'(slot_inc);
            state <= ST_FIN;
          end else begin
            col <= col_inc;
          end
        end

        // hand over to the output register
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            for (int k = 0; k < LANES; k++) begin
              out_match[k] <= (k < MAX_PORTS && 32'(k) < 32'(n))
                              ? DEST_W'(match_q[PORT_W'(k)]) : '0;
            end
            out_served <= served;
            out_sent   <= (32'(sent) > SENT_MAX) ? SENT_W'(SENT_MAX) : SENT_W'(sent);
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);

  // pack the result word
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < LANES; k++) begin
      m_tdata[k*DEST_W +: DEST_W] = out_match[k];
    end
    m_tdata[LANES*DEST_W +: LANES]         = out_served;
    m_tdata[LANES*DEST_W + LANES +: SENT_W] = out_sent;
  end

endmodule
